// File: rtl/ifp_pkg.sv
package ifp_pkg;

	// Frame layout
	localparam int FRAME_LEN = 11;
	localparam int SUM_LEN   = FRAME_LEN - 1;
	localparam int FILL_W    = $clog2(FRAME_LEN);
	localparam int BODY_LEN  = SUM_LEN - 2;

	// Header and frame type codes
	localparam logic [7:0] HEAD_BYTE   = 8'h55;
	localparam logic [7:0] TYPE_ACC    = 8'h51;
	localparam logic [7:0] TYPE_RATE   = 8'h52;
	localparam logic [7:0] TYPE_ANGLE  = 8'h53;
	localparam logic [7:0] TYPE_HEIGHT = 8'h56;

	typedef enum logic [1:0] {
		KIND_ACC    = 2'd0,
		KIND_RATE   = 2'd1,
		KIND_ANGLE  = 2'd2,
		KIND_HEIGHT = 2'd3
	} frame_kind_t;

	// Checked frame handed to the decode stage: kind and data bytes 2..9
	typedef struct packed {
		frame_kind_t          kind;
		logic [BODY_LEN*8-1:0] body;
	} frame_t;

	// Type byte to kind, with a flag for the types we report
	typedef struct packed {
		logic        known;
		frame_kind_t kind;
	} kind_dec_t;

	function automatic kind_dec_t decode_type(input logic [7:0] type_byte);
		kind_dec_t d;
		d.known = 1'b1;
		d.kind  = KIND_ACC;
		unique case (type_byte)
			TYPE_ACC:    d.kind = KIND_ACC;
			TYPE_RATE:   d.kind = KIND_RATE;
			TYPE_ANGLE:  d.kind = KIND_ANGLE;
			TYPE_HEIGHT: d.kind = KIND_HEIGHT;
			default:     d.known = 1'b0;
		endcase
		return d;
	endfunction

endpackage

// File: rtl/imu_frame_parser_top.sv
// A result word passes the stage 1 frame register and then the result register after the byte that completes its frame.
// Throughput: one byte per cycle while in_ready is high; the window update and checksum compare
// against a running sum are done on each byte as it is accepted, and the decode stage follows.
// Reset: arst_n clears the fill count, running checksum and both valid flags;
// the byte window itself needs no clearing since it is only read once full.
module imu_frame_parser_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         frame_kind,
	output logic signed [15:0] axis_x,
	output logic signed [15:0] axis_y,
	output logic signed [15:0] axis_z,
	output logic [31:0]        height_value
);
	import ifp_pkg::*;

	logic   frame_valid;
	logic   frame_ready;
	frame_t frame;

	// Sliding window and frame check
	ifp_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.frame_valid (frame_valid),
		.frame_ready (frame_ready),
		.frame       (frame)
	);

	// Field extraction and result register
	ifp_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_ready  (frame_ready),
		.frame        (frame),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_kind   (frame_kind),
		.axis_x       (axis_x),
		.axis_y       (axis_y),
		.axis_z       (axis_z),
		.height_value (height_value)
	);

endmodule

// File: rtl/ifp_window.sv
module ifp_window (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        rx_byte,
	output logic              frame_valid,
	input  logic              frame_ready,
	output ifp_pkg::frame_t   frame
);
	import ifp_pkg::*;

	localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(SUM_LEN);

	logic [7:0]        window_q [SUM_LEN];
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        sum_q;
	logic              frame_valid_s1;
	frame_t            frame_s1;

	logic      accept;
	logic      full;
	logic      hit;
	kind_dec_t type_dec;

	// Window check: the eleventh byte is the incoming word itself
	assign in_ready = !frame_valid_s1 || frame_ready;
	assign accept   = in_valid && in_ready;
	assign full     = (fill_q == FULL_FILL);
	assign hit      = full && (window_q[0] == HEAD_BYTE) && (sum_q == rx_byte);
	assign type_dec = decode_type(window_q[1]);

	// Fill count and running checksum of the stored bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			sum_q  <= '0;
		end else if (accept) begin
			if (!full) begin
				fill_q <= fill_q + 1'b1;
				sum_q  <= sum_q + rx_byte;
			end else if (hit) begin
				fill_q <= '0;
				sum_q  <= '0;
			end else begin
				// slide by one: oldest byte leaves, new word joins
				sum_q  <= sum_q - window_q[0] + rx_byte;
			end
		end
	end

	// Byte storage
	always_ff @(posedge clk) begin
		if (accept) begin
			if (!full) begin
				window_q[fill_q] <= rx_byte;
			end else if (!hit) begin
				for (int i = 0; i < SUM_LEN - 1; i++) begin
					window_q[i] <= window_q[i+1];
				end
				window_q[SUM_LEN-1] <= rx_byte;
			end
		end
	end

	// Stage 1 register: a good frame of a reported type
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			frame_valid_s1 <= accept && hit && type_dec.known;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hit) begin
			frame_s1.kind <= type_dec.kind;
			for (int i = 0; i < BODY_LEN; i++) begin
				frame_s1.body[i*8 +: 8] <= window_q[i+2];
			end
		end
	end

	assign frame_valid = frame_valid_s1;
	assign frame       = frame_s1;

endmodule

// File: rtl/ifp_decode.sv
module ifp_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               frame_valid,
	output logic               frame_ready,
	input  ifp_pkg::frame_t    frame,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         frame_kind,
	output logic signed [15:0] axis_x,
	output logic signed [15:0] axis_y,
	output logic signed [15:0] axis_z,
	output logic [31:0]        height_value
);
	import ifp_pkg::*;

	logic               out_valid_q;
	frame_kind_t        kind_q;
	logic signed [15:0] axis_x_q;
	logic signed [15:0] axis_y_q;
	logic signed [15:0] axis_z_q;
	logic [31:0]        height_q;

	logic               load;
	logic               is_height;

	assign frame_ready = !out_valid_q || out_ready;
	assign load        = frame_valid && frame_ready;
	assign is_height   = (frame.kind == KIND_HEIGHT);

	// Result word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (frame_ready) begin
			out_valid_q <= frame_valid;
		end
	end

	// Result fields: three little-endian axes, or a 32-bit height
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= frame.kind;
			if (is_height) begin
				axis_x_q <= '0;
				axis_y_q <= '0;
				axis_z_q <= '0;
				height_q <= frame.body[63:32];
			end else begin
				axis_x_q <= signed'(frame.body[15:0]);
				axis_y_q <= signed'(frame.body[31:16]);
				axis_z_q <= signed'(frame.body[47:32]);
				height_q <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_kind   = kind_q;
	assign axis_x       = axis_x_q;
	assign axis_y       = axis_y_q;
	assign axis_z       = axis_z_q;
	assign height_value = height_q;

endmodule
